[design/assert_macros.svh]
// Shared assertion wrappers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// clocked property that must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
	else $error("forbidden condition seen");

`endif

[design/mfqs_pkg.sv]
package mfqs_pkg;

	localparam int TASK_W         = 4;
	localparam int ACT_W          = 2;
	localparam int QUANT_W        = 8;
	localparam int USAGE_W        = 8;
	localparam int USAGE_DEPTH    = 1 << TASK_W;
	localparam int TASK_COUNT_DEF = 16;
	localparam int CFG_IDX_W      = 1;
	localparam logic [QUANT_W-1:0] Q1_RST = 8'd8;
	localparam logic [QUANT_W-1:0] Q2_RST = 8'd16;

	typedef logic [TASK_W-1:0] task_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_PICK   = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_Q1 = 1'b0,
		CFG_Q2 = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		LVL_ONE   = 2'd0,
		LVL_TWO   = 2'd1,
		LVL_THREE = 2'd2
	} lvl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_SCAN,
		ST_REM_SCAN,
		ST_PICK_CHK,
		ST_PICK_EVAL,
		ST_DEM_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		USE_KEEP,
		USE_CLR,
		USE_INC
	} usage_op_t;

	typedef enum logic [1:0] {
		RES_KEEP,
		RES_HEAD,
		RES_TARGET
	} res_sel_t;

	typedef struct packed {
		logic      start;
		logic      lvl_inc;
		logic      scan_clr;
		logic      scan_inc;
		logic      scan_next;
		logic      append;
		logic      rm_scan;
		logic      rm_demote;
		logic      load_target;
		usage_op_t usage_op;
		res_sel_t  res_sel;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		lvl_t lvl;
		logic task_ok;
		logic cnt_zero;
		logic cnt_one;
		logic scan_end;
		logic scan_hit;
		logic scan_full;
		logic use_zero;
		logic use_over;
		logic out_free;
	} status_t;

endpackage

[design/multilevel_feedback_queue_scheduler.sv]
// Add scans level one and appends the task if it is absent; remove scans the three levels in turn.
// Pick walks the levels in order and may demote an over-quantum task before it checks the level again.
// Throughput: one transaction at a time; the controller stalls requests until it is back in idle.
// A finished result waits in the output register while the next transaction is taken.
// Reset (arst_n low, asynchronous): queues empty, positions and usage zero, quanta 8 and 16.
`include "assert_macros.svh"

module multilevel_feedback_queue_scheduler import mfqs_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ACT_W-1:0]     action,
	input  logic [TASK_W-1:0]    task_id,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 picked_valid,
	output logic [TASK_W-1:0]    picked_task,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [QUANT_W-1:0]   cfg_data
);

	cmd_t    cmd;
	status_t sts;

	// quantum registers take a write in any cycle
	assign cfg_ready = 1'b1;

	// controller: walks scans, demotions and result hand-off
	mfqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (action),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// datapath: three level queues, usage table, quanta, output register
	mfqs_datapath #(
		.TASK_COUNT (TASK_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.task_id      (task_id),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.picked_valid (picked_valid),
		.picked_task  (picked_task)
	);

	// an empty pick reports task zero
	`ASSERT_CLK(a_empty_task_zero, clk, arst_n, (out_valid && !picked_valid) |-> (picked_task == '0))
	// a taken transaction holds off the next one
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	// results only come out of a transaction in flight
	`ASSERT_CLK(a_result_from_work, clk, arst_n, $rose(out_valid) |-> $past(in_stall))
	// no append into a full level
	`ASSERT_NEVER(a_no_overflow, clk, arst_n, cmd.append && sts.scan_full)

endmodule

[design/mfqs_ctrl.sv]
module mfqs_ctrl import mfqs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [ACT_W-1:0]     action,
	input  status_t              sts,
	output logic                 in_stall,
	output cmd_t                 cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (action_t'(action))
						ACT_ADD:    state_nxt = sts.task_ok ? ST_ADD_SCAN : ST_DONE;
						ACT_REMOVE: state_nxt = sts.task_ok ? ST_REM_SCAN : ST_DONE;
						ACT_PICK:   state_nxt = ST_PICK_CHK;
						default:    state_nxt = ST_DONE;
					endcase
				end
			end
			ST_ADD_SCAN: begin
				if (sts.scan_end || sts.scan_hit) state_nxt = ST_DONE;
			end
			ST_REM_SCAN: begin
				if ((sts.scan_end || sts.scan_hit) && sts.lvl == LVL_THREE) state_nxt = ST_DONE;
			end
			ST_PICK_CHK: begin
				if (sts.lvl == LVL_THREE || sts.cnt_one) state_nxt = ST_DONE;
				else if (!sts.cnt_zero) state_nxt = ST_PICK_EVAL;
			end
			ST_PICK_EVAL: begin
				state_nxt = (!sts.use_zero && sts.use_over) ? ST_DEM_SCAN : ST_DONE;
			end
			ST_DEM_SCAN: begin
				if (sts.scan_end || sts.scan_hit) state_nxt = ST_PICK_CHK;
			end
			ST_DONE: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.start = in_valid;
			end
			ST_ADD_SCAN: begin
				cmd.append   = sts.scan_end && !sts.scan_full;
				cmd.scan_inc = !sts.scan_end && !sts.scan_hit;
			end
			ST_REM_SCAN: begin
				cmd.rm_scan = sts.scan_hit;
				if (sts.scan_end || sts.scan_hit) begin
					if (sts.lvl == LVL_THREE) begin
						cmd.usage_op = USE_CLR;
					end else begin
						cmd.lvl_inc  = 1'b1;
						cmd.scan_clr = 1'b1;
					end
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			ST_PICK_CHK: begin
				if (sts.lvl == LVL_THREE) begin
					if (!sts.cnt_zero) cmd.res_sel = RES_HEAD;
				end else if (sts.cnt_zero) begin
					cmd.lvl_inc = 1'b1;
				end else if (sts.cnt_one) begin
					cmd.res_sel = RES_HEAD;
				end else begin
					cmd.load_target = 1'b1;
				end
			end
			ST_PICK_EVAL: begin
				if (!sts.use_zero && sts.use_over) begin
					cmd.usage_op = USE_CLR;
					cmd.scan_clr = 1'b1;
				end else begin
					cmd.usage_op = USE_INC;
					cmd.res_sel  = RES_TARGET;
				end
			end
			ST_DEM_SCAN: begin
				cmd.scan_next = 1'b1;
				cmd.append    = sts.scan_end && !sts.scan_full;
				cmd.rm_demote = sts.scan_end || sts.scan_hit;
				cmd.scan_inc  = !sts.scan_end && !sts.scan_hit;
			end
			ST_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

[design/mfqs_datapath.sv]
module mfqs_datapath import mfqs_pkg::*; #(
	parameter int TASK_COUNT = TASK_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              sts,
	input  logic [TASK_W-1:0]    task_id,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [QUANT_W-1:0]   cfg_data,
	input  logic                 out_stall,
	output logic                 out_valid,
	output logic                 picked_valid,
	output logic [TASK_W-1:0]    picked_task
);

	localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
	localparam int CW = $clog2(TASK_COUNT + 1);

	task_t               q_q     [3][TASK_COUNT];
	logic [CW-1:0]       cnt_q   [3];
	logic [IW-1:0]       pos_q   [2];
	logic [USAGE_W-1:0]  usage_q [USAGE_DEPTH];
	logic [QUANT_W-1:0]  quant_q [2];
	lvl_t                lvl_q;
	logic [CW-1:0]       scan_q;
	task_t               target_q;
	logic                res_valid_q;
	task_t               res_task_q;
	logic                out_valid_q;
	logic                picked_valid_q;
	task_t               picked_task_q;

	lvl_t                scan_lvl;
	logic [IW-1:0]       rd_addr;
	logic [IW-1:0]       rm_idx;
	task_t               entry;
	task_t               head;
	logic [USAGE_W-1:0]  use_val;
	logic                scan_end;

	assign scan_lvl = cmd.scan_next ? lvl_t'(lvl_q + 2'd1) : lvl_q;
	assign rd_addr  = cmd.load_target ? pos_q[lvl_q[0]] : scan_q[IW-1:0];
	assign rm_idx   = cmd.rm_demote ? pos_q[lvl_q[0]] : scan_q[IW-1:0];
	assign entry    = q_q[scan_lvl][rd_addr];
	assign head     = q_q[lvl_q][0];
	assign use_val  = usage_q[target_q];
	assign scan_end = (scan_q >= cnt_q[scan_lvl]);

	always_comb begin
		sts.lvl       = lvl_q;
		sts.task_ok   = (32'(task_id) < TASK_COUNT);
		sts.cnt_zero  = (cnt_q[lvl_q] == '0);
		sts.cnt_one   = (cnt_q[lvl_q] == CW'(1));
		sts.scan_end  = scan_end;
		sts.scan_hit  = !scan_end && (entry == target_q);
		sts.scan_full = (cnt_q[scan_lvl] == CW'(TASK_COUNT));
		sts.use_zero  = (use_val == '0);
		sts.use_over  = (use_val >= quant_q[lvl_q[0]]);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// queue entries, no reset (only entries below the count are read)
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (cmd.append && scan_lvl == lvl_t'(k)) begin
				q_q[k][cnt_q[k][IW-1:0]] <= target_q;
			end
			if ((cmd.rm_scan || cmd.rm_demote) && lvl_q == lvl_t'(k)) begin
				for (int i = 0; i < TASK_COUNT - 1; i++) begin
					if (IW'(i) >= rm_idx) q_q[k][i] <= q_q[k][i+1];
				end
			end
		end
	end

	// counts and positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) cnt_q[k] <= '0;
			for (int k = 0; k < 2; k++) pos_q[k] <= '0;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (cmd.append && scan_lvl == lvl_t'(k)) begin
					cnt_q[k] <= cnt_q[k] + CW'(1);
				end else if ((cmd.rm_scan || cmd.rm_demote) && lvl_q == lvl_t'(k)) begin
					cnt_q[k] <= cnt_q[k] - CW'(1);
				end
			end
			for (int k = 0; k < 2; k++) begin
				if (lvl_q == lvl_t'(k)) begin
					if (cmd.rm_scan) begin
						// step back one, wrapping to the new last entry
						if (cnt_q[k] <= CW'(1))
							pos_q[k] <= '0;
						else if (pos_q[k] == '0)
							pos_q[k] <= IW'(cnt_q[k] - CW'(2));
						else
							pos_q[k] <= pos_q[k] - IW'(1);
					end else if (cmd.rm_demote) begin
						// step back then forward: only a tail position wraps
						if (cnt_q[k] <= CW'(2))
							pos_q[k] <= '0;
						else if (CW'(pos_q[k]) == cnt_q[k] - CW'(1))
							pos_q[k] <= '0;
					end
				end
			end
		end
	end

	// usage counts and quantum registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < USAGE_DEPTH; i++) usage_q[i] <= '0;
			quant_q[0] <= Q1_RST;
			quant_q[1] <= Q2_RST;
		end else begin
			case (cmd.usage_op)
				USE_CLR:  usage_q[target_q] <= '0;
				USE_INC:  usage_q[target_q] <= use_val + USAGE_W'(1);
				default:  ;
			endcase
			if (cfg_valid) begin
				case (cfg_idx_t'(cfg_index))
					CFG_Q1:  quant_q[0] <= cfg_data;
					CFG_Q2:  quant_q[1] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q       <= LVL_ONE;
			scan_q      <= '0;
			res_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start)        lvl_q <= LVL_ONE;
			else if (cmd.lvl_inc) lvl_q <= lvl_t'(lvl_q + 2'd1);
			if (cmd.start || cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_inc)         scan_q <= scan_q + CW'(1);
			if (cmd.start)                     res_valid_q <= 1'b0;
			else if (cmd.res_sel != RES_KEEP)  res_valid_q <= 1'b1;
			if (cmd.out_load)                  out_valid_q <= 1'b1;
			else if (!out_stall)               out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start)            target_q <= task_id;
		else if (cmd.load_target) target_q <= entry;
		case (cmd.res_sel)
			RES_HEAD:   res_task_q <= head;
			RES_TARGET: res_task_q <= target_q;
			default:    if (cmd.start) res_task_q <= '0;
		endcase
		if (cmd.out_load) begin
			picked_valid_q <= res_valid_q;
			picked_task_q  <= res_task_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign picked_valid = picked_valid_q;
	assign picked_task  = picked_task_q;

endmodule
